[sv/rsms_pkg.sv]
package rsms_pkg;

	// limits of the machine
	localparam logic [7:0]  STATE_LIMIT = 8'd15;
	localparam logic [7:0]  BOX_LIMIT   = 8'd15;
	localparam logic [7:0]  LABEL_LIMIT = 8'd15;
	localparam logic [15:0] INDEX_MAX   = 16'd255;
	localparam int          STACK_DEPTH = 16;

	// widths
	localparam int DEPTH_W      = 5;
	localparam int SLOT_W       = $clog2(STACK_DEPTH);
	localparam int KEY_W        = 12;
	localparam int RULE_ENTRIES = 1 << KEY_W;
	localparam int QUEUE_DEPTH  = 2;
	localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);

	typedef enum logic [1:0] {
		OP_LOAD    = 2'd0,
		OP_RESTART = 2'd1,
		OP_PUSH    = 2'd2,
		OP_STEP    = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		BK_CLEAR = 2'd0,
		BK_RUN   = 2'd1,
		BK_LOOK  = 2'd2
	} back_state_t;

	// classified command passed from front to back
	typedef struct packed {
		op_t        op;
		logic       ok;
		logic [3:0] label;
		logic [7:0] lidx;
		logic [3:0] state;
		logic [3:0] box;
		logic [7:0] idx;
		logic [3:0] dst;
		logic [3:0] dbox;
		logic       present;
	} cmd_t;

	typedef struct packed {
		logic       valid;
		logic [3:0] dst;
		logic [3:0] box;
	} rule_t;

	typedef struct packed {
		logic [3:0] box;
		logic [7:0] idx;
	} frame_t;

	function automatic logic [KEY_W-1:0] rule_key(input logic [3:0] s, input logic [3:0] b,
		input logic [3:0] l);
		rule_key = {s, b, l};
	endfunction

	function automatic logic [7:0] sat_index(input logic [7:0] v);
		sat_index = (16'(v) > INDEX_MAX) ? INDEX_MAX[7:0] : v;
	endfunction

endpackage

[sv/rsms_front.sv]
module rsms_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               item_valid,
	output logic               item_stall,
	input  logic [1:0]         operation,
	input  logic [3:0]         label_id,
	input  logic [7:0]         label_index,
	input  logic [3:0]         source_state,
	input  logic [3:0]         frame_box,
	input  logic [7:0]         frame_index,
	input  logic [3:0]         target_state,
	input  logic [3:0]         target_box,
	input  logic               rule_present,
	output logic               q_valid,
	output rsms_pkg::cmd_t     q_item,
	input  logic               q_pop
);

	rsms_pkg::cmd_t cmd;
	rsms_pkg::cmd_t fifo_q [rsms_pkg::QUEUE_DEPTH];
	logic [rsms_pkg::QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [rsms_pkg::QCNT_W-1:0] cnt_q;
	logic push;

	// classify the incoming beat
	always_comb begin
		cmd         = '0;
		cmd.op      = rsms_pkg::op_t'(operation);
		cmd.label   = label_id;
		cmd.lidx    = rsms_pkg::sat_index(label_index);
		cmd.state   = source_state;
		cmd.box     = frame_box;
		cmd.idx     = rsms_pkg::sat_index(frame_index);
		cmd.dst     = target_state;
		cmd.dbox    = target_box;
		cmd.present = rule_present;
		unique case (cmd.op)
			rsms_pkg::OP_LOAD: begin
				cmd.ok = (label_id != 4'd0) && (8'(label_id) <= rsms_pkg::LABEL_LIMIT)
					&& (8'(source_state) <= rsms_pkg::STATE_LIMIT)
					&& (8'(frame_box) <= rsms_pkg::BOX_LIMIT)
					&& (8'(target_state) <= rsms_pkg::STATE_LIMIT)
					&& (8'(target_box) <= rsms_pkg::BOX_LIMIT);
			end
			rsms_pkg::OP_RESTART: begin
				cmd.ok = 8'(source_state) <= rsms_pkg::STATE_LIMIT;
			end
			rsms_pkg::OP_PUSH: begin
				cmd.ok = (frame_box != 4'd0) && (8'(frame_box) <= rsms_pkg::BOX_LIMIT);
			end
			rsms_pkg::OP_STEP: begin
				cmd.ok = label_id != 4'd0;
			end
			default: cmd.ok = 1'b0;
		endcase
	end

	// small queue between front and back
	assign item_stall = cnt_q == rsms_pkg::QCNT_W'(rsms_pkg::QUEUE_DEPTH);
	assign push       = item_valid && !item_stall;
	assign q_valid    = cnt_q != '0;
	assign q_item     = fifo_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (q_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !q_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (!push && q_pop) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q] <= cmd;
		end
	end

endmodule

[sv/rsms_back.sv]
module rsms_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           q_valid,
	input  rsms_pkg::cmd_t q_item,
	output logic           q_pop,
	output logic           result_valid,
	input  logic           result_stall,
	output logic [3:0]     current_state,
	output logic [4:0]     depth_now,
	output logic [3:0]     top_box,
	output logic [7:0]     top_index,
	output logic           dead,
	output logic           overflowed
);

	localparam int DW = rsms_pkg::DEPTH_W;
	localparam int SW = rsms_pkg::SLOT_W;
	localparam int KW = rsms_pkg::KEY_W;

	rsms_pkg::back_state_t st_q, st_d;
	rsms_pkg::rule_t rule_mem [rsms_pkg::RULE_ENTRIES];
	rsms_pkg::rule_t rd_a_q, rd_b_q, mem_wdata;
	rsms_pkg::frame_t frames_q [rsms_pkg::STACK_DEPTH];
	rsms_pkg::frame_t below;
	rsms_pkg::cmd_t look_s1, look_d;

	logic [KW-1:0] clr_q, clr_d, mem_waddr, rd_addr_a, rd_addr_b;
	logic          mem_we, rd_en;
	logic [3:0]    ls_q, ls_d, top_box_q, tb_d;
	logic [7:0]    top_idx_q, ti_d;
	logic [DW-1:0] cnt_q, cnt_d, cnt_pop, cnt_below;
	logic          fr_we, ovf, emit, can_emit, full;
	logic [SW-1:0] fr_slot;
	rsms_pkg::frame_t fr_data;

	assign can_emit  = !result_valid || !result_stall;
	assign full      = cnt_q >= DW'(rsms_pkg::STACK_DEPTH);
	assign cnt_pop   = cnt_q - DW'(1);
	assign cnt_below = cnt_q - DW'(2);
	assign below     = frames_q[cnt_below[SW-1:0]];

	// next state and datapath control
	always_comb begin
		st_d      = st_q;
		q_pop     = 1'b0;
		mem_we    = 1'b0;
		mem_waddr = clr_q;
		mem_wdata = '0;
		clr_d     = clr_q;
		rd_en     = 1'b0;
		rd_addr_a = rsms_pkg::rule_key(ls_q, 4'd0, q_item.label);
		rd_addr_b = rsms_pkg::rule_key(ls_q, top_box_q, q_item.label);
		look_d    = look_s1;
		ls_d      = ls_q;
		cnt_d     = cnt_q;
		tb_d      = top_box_q;
		ti_d      = top_idx_q;
		fr_we     = 1'b0;
		fr_slot   = cnt_q[SW-1:0];
		fr_data   = '0;
		ovf       = 1'b0;
		emit      = 1'b0;
		unique case (st_q)
			rsms_pkg::BK_CLEAR: begin
				// sweep the rule table to invalid
				mem_we = 1'b1;
				clr_d  = clr_q + 1'b1;
				if (clr_q == KW'(rsms_pkg::RULE_ENTRIES - 1)) begin
					st_d = rsms_pkg::BK_RUN;
				end
			end
			rsms_pkg::BK_RUN: begin
				if (q_valid && can_emit) begin
					q_pop = 1'b1;
					unique case (q_item.op)
						rsms_pkg::OP_LOAD: begin
							emit = 1'b1;
							if (q_item.ok) begin
								mem_we    = 1'b1;
								mem_waddr = rsms_pkg::rule_key(q_item.state, q_item.box,
									q_item.label);
								mem_wdata = q_item.present ? {1'b1, q_item.dst, q_item.dbox} : '0;
							end
						end
						rsms_pkg::OP_RESTART: begin
							emit  = 1'b1;
							ls_d  = q_item.ok ? q_item.state : 4'd0;
							cnt_d = '0;
						end
						rsms_pkg::OP_PUSH: begin
							emit = 1'b1;
							if (q_item.ok) begin
								if (full) begin
									ovf  = 1'b1;
									ls_d = 4'd0;
								end else begin
									fr_we   = 1'b1;
									fr_data = {q_item.box, q_item.idx};
									cnt_d   = cnt_q + DW'(1);
									tb_d    = q_item.box;
									ti_d    = q_item.idx;
								end
							end
						end
						rsms_pkg::OP_STEP: begin
							if (ls_q == 4'd0 || !q_item.ok) begin
								emit  = 1'b1;
								ls_d  = 4'd0;
								cnt_d = '0;
							end else begin
								// fetch box-free and boxed rules together
								rd_en  = 1'b1;
								look_d = q_item;
								st_d   = rsms_pkg::BK_LOOK;
							end
						end
						default: ;
					endcase
				end
			end
			rsms_pkg::BK_LOOK: begin
				if (can_emit) begin
					emit = 1'b1;
					st_d = rsms_pkg::BK_RUN;
					if (rd_a_q.valid) begin
						// box-free move, maybe entering a box
						ls_d = rd_a_q.dst;
						if (rd_a_q.box != 4'd0) begin
							if (full) begin
								ovf  = 1'b1;
								ls_d = 4'd0;
							end else begin
								fr_we   = 1'b1;
								fr_data = {rd_a_q.box, look_s1.lidx};
								cnt_d   = cnt_q + DW'(1);
								tb_d    = rd_a_q.box;
								ti_d    = look_s1.lidx;
							end
						end
					end else if (cnt_q == '0) begin
						ls_d = 4'd0;
					end else begin
						// pop the top frame, then try the boxed rule
						cnt_d = cnt_pop;
						tb_d  = below.box;
						ti_d  = below.idx;
						ls_d  = 4'd0;
						if (rd_b_q.valid && top_idx_q == look_s1.lidx) begin
							ls_d = rd_b_q.dst;
							if (rd_b_q.box != 4'd0) begin
								fr_we   = 1'b1;
								fr_slot = cnt_pop[SW-1:0];
								fr_data = {rd_b_q.box, look_s1.lidx};
								cnt_d   = cnt_q;
								tb_d    = rd_b_q.box;
								ti_d    = look_s1.lidx;
							end
						end
					end
				end
			end
			default: st_d = rsms_pkg::BK_CLEAR;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q         <= rsms_pkg::BK_CLEAR;
			clr_q        <= '0;
			ls_q         <= '0;
			cnt_q        <= '0;
			result_valid <= 1'b0;
		end else begin
			st_q  <= st_d;
			clr_q <= clr_d;
			ls_q  <= ls_d;
			cnt_q <= cnt_d;
			if (emit) begin
				result_valid <= 1'b1;
			end else if (!result_stall) begin
				result_valid <= 1'b0;
			end
		end
	end

	// rule table, two registered read ports
	always_ff @(posedge clk) begin
		if (mem_we) begin
			rule_mem[mem_waddr] <= mem_wdata;
		end
		if (rd_en) begin
			rd_a_q <= rule_mem[rd_addr_a];
			rd_b_q <= rule_mem[rd_addr_b];
		end
	end

	// frame stack, top cache and result beat
	always_ff @(posedge clk) begin
		look_s1   <= look_d;
		top_box_q <= tb_d;
		top_idx_q <= ti_d;
		if (fr_we) begin
			frames_q[fr_slot] <= fr_data;
		end
		if (emit) begin
			current_state <= ls_d;
			depth_now     <= cnt_d;
			top_box       <= (cnt_d == '0) ? 4'd0 : tb_d;
			top_index     <= (cnt_d == '0) ? 8'd0 : ti_d;
			dead          <= ls_d == 4'd0;
			overflowed    <= ovf;
		end
	end

endmodule

[sv/recursive_state_machine_step.sv]
// Flow: a beat accepted into the front queue is popped by the back, which registers the result
// for load, restart, push and dead steps; a live step first passes the registered rule-table read.
// Throughput: one item per cycle while the result is not stalled; a live step holds off the next
// item until its BK_LOOK state ends, set by the rule-table read feeding the next local state.
// Reset: arst_n clears control state, then a sweep over all 4096 rule-table entries invalidates
// the rule table, during which items queue but none is executed.
module recursive_state_machine_step (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       item_valid,
	output logic       item_stall,
	input  logic [1:0] operation,
	input  logic [3:0] label_id,
	input  logic [7:0] label_index,
	input  logic [3:0] source_state,
	input  logic [3:0] frame_box,
	input  logic [7:0] frame_index,
	input  logic [3:0] target_state,
	input  logic [3:0] target_box,
	input  logic       rule_present,
	output logic       result_valid,
	input  logic       result_stall,
	output logic [3:0] current_state,
	output logic [4:0] depth_now,
	output logic [3:0] top_box,
	output logic [7:0] top_index,
	output logic       dead,
	output logic       overflowed
);

	logic           q_valid, q_pop;
	rsms_pkg::cmd_t q_item;

	// accept and classify
	rsms_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.operation    (operation),
		.label_id     (label_id),
		.label_index  (label_index),
		.source_state (source_state),
		.frame_box    (frame_box),
		.frame_index  (frame_index),
		.target_state (target_state),
		.target_box   (target_box),
		.rule_present (rule_present),
		.q_valid      (q_valid),
		.q_item       (q_item),
		.q_pop        (q_pop)
	);

	// execute against rule table and stack
	rsms_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.q_valid       (q_valid),
		.q_item        (q_item),
		.q_pop         (q_pop),
		.result_valid  (result_valid),
		.result_stall  (result_stall),
		.current_state (current_state),
		.depth_now     (depth_now),
		.top_box       (top_box),
		.top_index     (top_index),
		.dead          (dead),
		.overflowed    (overflowed)
	);

endmodule

[sv/rsms_checker.sv]
module rsms_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       item_valid,
	input logic       item_stall,
	input logic [1:0] operation,
	input logic [3:0] label_id,
	input logic [7:0] label_index,
	input logic [3:0] source_state,
	input logic [3:0] frame_box,
	input logic [7:0] frame_index,
	input logic [3:0] target_state,
	input logic [3:0] target_box,
	input logic       rule_present,
	input logic       result_valid,
	input logic       result_stall,
	input logic [3:0] current_state,
	input logic [4:0] depth_now,
	input logic [3:0] top_box,
	input logic [7:0] top_index,
	input logic       dead,
	input logic       overflowed
);

	// dead flag tracks the state
	a_dead: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (dead == (current_state == 4'd0)))
		else $error("dead flag disagrees with current_state");

	// an empty stack shows no top frame
	a_empty_top: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && depth_now == 5'd0) |-> (top_box == 4'd0 && top_index == 8'd0))
		else $error("empty stack shows a top frame");

	// depth stays within the stack
	a_depth: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (32'(depth_now) <= rsms_pkg::STACK_DEPTH))
		else $error("depth beyond stack size");

	// overflow always kills the machine on a full stack
	a_ovf: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && overflowed) |->
			(dead && 32'(depth_now) == rsms_pkg::STACK_DEPTH))
		else $error("overflow without dead state on a full stack");

	// a stalled result beat holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result_stall) |=> (result_valid && $stable(current_state)
			&& $stable(depth_now) && $stable(top_box) && $stable(top_index)
			&& $stable(dead) && $stable(overflowed)))
		else $error("stalled result beat changed");

endmodule

bind recursive_state_machine_step rsms_checker u_rsms_checker (.*);
